// File: rtl/capacitive_channel_scanner_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the capacitive channel scanner
// Both macros check one property per clock edge and are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef CAPACITIVE_CHANNEL_SCANNER_ASSERT_SVH
`define CAPACITIVE_CHANNEL_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("capacitive channel scanner assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("capacitive channel scanner assertion failed");

`endif

// File: rtl/ccs_pkg.sv
// ---------------------------------------------------------------------------
// Capacitive channel scanner package
// Types, codes and helper functions shared by the scanner modules.
// ---------------------------------------------------------------------------
package ccs_pkg;

    localparam int MAX_CHANNELS    = 8;
    localparam int DEFAULT_CHANNELS = 8;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 8;
    localparam logic [7:0] CROSSINGS_RESET = 8'd20;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLED   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CROSSINGS = 1'b1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_CROSS = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic {
        KIND_MEASURE = 1'b0,
        KIND_READ    = 1'b1
    } kind_t;

    typedef struct packed {
        logic [2:0] read_channel;
        op_t        operation;
    } item_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [2:0]  channel;
        logic [15:0] value;
        logic        scan_done;
        logic        busy_res;
    } result_t;

    typedef struct packed {
        logic       measuring;
        logic [7:0] pending_mask;
    } status_t;

    // Index of the highest set bit; zero for an empty mask.
    function automatic logic [2:0] highest_bit(input logic [7:0] mask);
        logic [2:0] idx;
        idx = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (mask[b]) begin
                idx = 3'(b);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/ccs_in_reg.sv
// ---------------------------------------------------------------------------
// Input register
// Holds one accepted transaction until the engine takes it.
// ---------------------------------------------------------------------------
module ccs_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ccs_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output ccs_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    ccs_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/ccs_engine.sv
// ---------------------------------------------------------------------------
// Scan engine
// Scan state, configuration, value store and the per-transaction update.
// ---------------------------------------------------------------------------
module ccs_engine #(
    parameter int NUM_CHANNELS = ccs_pkg::DEFAULT_CHANNELS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ccs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           item_valid,
    input  ccs_pkg::item_t                 item,
    input  logic                           advance,
    output logic                           res_valid,
    output ccs_pkg::result_t               res,
    output ccs_pkg::status_t               status
);

    localparam logic [7:0] CHAN_MASK = 8'((9'd1 << NUM_CHANNELS) - 9'd1);

    logic [7:0]  enabled_reg;
    logic [7:0]  crossings_reg;
    logic [7:0]  pending_reg,  pending_next;
    logic [2:0]  current_reg,  current_next;
    logic [7:0]  count_reg,    count_next;
    logic [15:0] elapsed_reg,  elapsed_next;
    logic        measuring_reg, measuring_next;
    logic [15:0] store_reg [NUM_CHANNELS];

    logic        fire;
    logic        capture;
    logic [7:0]  usable;
    logic [7:0]  count_inc;
    logic [7:0]  cleared;
    logic [15:0] store_rdata;

    assign fire   = item_valid && advance;
    assign usable = enabled_reg & CHAN_MASK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 8'd0;
            crossings_reg <= ccs_pkg::CROSSINGS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ccs_pkg::CFG_ENABLED:   enabled_reg   <= cfg_wdata;
                ccs_pkg::CFG_CROSSINGS: crossings_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Channels at or above the channel count read back as zero.
    always_comb begin
        store_rdata = 16'd0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (item.read_channel == 3'(i)) begin
                store_rdata = store_reg[i];
            end
        end
    end

    always_comb begin
        pending_next   = pending_reg;
        current_next   = current_reg;
        count_next     = count_reg;
        elapsed_next   = elapsed_reg;
        measuring_next = measuring_reg;
        capture        = 1'b0;
        res_valid      = 1'b0;
        count_inc      = count_reg + 8'd1;
        cleared        = pending_reg & ~(8'd1 << current_reg);
        res.result_kind = ccs_pkg::KIND_MEASURE;
        res.channel     = current_reg;
        res.value       = elapsed_reg;
        res.scan_done   = (cleared == 8'd0);
        res.busy_res    = (cleared != 8'd0);

        unique case (item.operation)
            ccs_pkg::OP_START: begin
                // A start during a scan keeps the pending set and restarts the channel.
                if (usable != 8'd0) begin
                    if (pending_reg == 8'd0) begin
                        pending_next = usable;
                        current_next = ccs_pkg::highest_bit(usable);
                    end
                    count_next     = 8'd0;
                    elapsed_next   = 16'd0;
                    measuring_next = 1'b1;
                end
            end
            ccs_pkg::OP_TICK: begin
                if (measuring_reg) begin
                    elapsed_next = elapsed_reg + 16'd1;
                end
            end
            ccs_pkg::OP_CROSS: begin
                if (measuring_reg) begin
                    if (count_inc != crossings_reg) begin
                        count_next = count_inc;
                    end else begin
                        capture        = 1'b1;
                        res_valid      = 1'b1;
                        pending_next   = cleared;
                        count_next     = 8'd0;
                        elapsed_next   = 16'd0;
                        measuring_next = 1'b0;
                        if (cleared != 8'd0) begin
                            current_next   = ccs_pkg::highest_bit(cleared);
                            measuring_next = (usable != 8'd0);
                        end
                    end
                end
            end
            ccs_pkg::OP_READ: begin
                res_valid       = 1'b1;
                res.result_kind = ccs_pkg::KIND_READ;
                res.channel     = item.read_channel;
                res.value       = store_rdata;
                res.scan_done   = 1'b0;
                res.busy_res    = (pending_reg != 8'd0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 8'd0;
            current_reg   <= 3'd0;
            count_reg     <= 8'd0;
            elapsed_reg   <= 16'd0;
            measuring_reg <= 1'b0;
        end else if (fire) begin
            pending_reg   <= pending_next;
            current_reg   <= current_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            measuring_reg <= measuring_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!aresetn) begin
                store_reg[i] <= 16'd0;
            end else if (fire && capture && current_reg == 3'(i)) begin
                store_reg[i] <= elapsed_reg;
            end
        end
    end

    assign status.measuring    = measuring_reg;
    assign status.pending_mask = pending_reg;

endmodule

// File: rtl/ccs_out_reg.sv
// ---------------------------------------------------------------------------
// Output register
// Holds a finished result until the downstream side takes it.
// ---------------------------------------------------------------------------
module ccs_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  logic             res_valid,
    input  ccs_pkg::result_t res,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_ready,
    output ccs_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    ccs_pkg::result_t res_reg;

    // The register frees up in the same cycle its contents are taken.
    assign advance    = !valid_reg || out_ready;
    assign valid_next = advance ? (item_valid && res_valid) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// File: rtl/capacitive_channel_scanner.sv
// ---------------------------------------------------------------------------
// Capacitive channel scanner
// Scans enabled channels highest first and reports elapsed ticks per channel.
// ---------------------------------------------------------------------------
// The scanner takes one transaction per clock cycle while the result side is
// ready. An accepted transaction is held in the input register and its
// result, if any, in the output register. Only comparator crossings that
// complete a measurement and read requests produce results; starts and ticks
// do not. Sustained throughput is one transaction per cycle as long as the
// result side is ready; the scan state updates once per transaction.
// Configuration writes take effect on the next cycle and should only be made
// while no transaction is in flight.
module capacitive_channel_scanner #(
    parameter int NUM_CHANNELS = ccs_pkg::DEFAULT_CHANNELS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ccs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [2:0] read_channel, rest zero
    input  logic [1:0]                     s_tuser,  // [1:0] operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,  // [2:0] channel, [18:3] value,
                                                     // [19] busy_res, rest zero
    output logic [0:0]                     m_tuser,  // [0] result_kind
    output logic                           m_tlast   // scan_done
);

    ccs_pkg::item_t   in_item;
    ccs_pkg::item_t   item;
    ccs_pkg::result_t res;
    ccs_pkg::result_t out_res;
    ccs_pkg::status_t status;
    logic             item_valid;
    logic             advance;
    logic             res_valid;

    assign in_item.operation    = ccs_pkg::op_t'(s_tuser);
    assign in_item.read_channel = s_tdata[2:0];

    ccs_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ccs_engine #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res),
        .status     (status)
    );

    ccs_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .res_valid  (res_valid),
        .res        (res),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = {4'd0, out_res.busy_res, out_res.value, out_res.channel};
    assign m_tuser = out_res.result_kind;
    assign m_tlast = out_res.scan_done;

`include "capacitive_channel_scanner_assert.svh"

    // A channel is only measured while some channel is still pending.
    `CCS_ASSERT_SAME(a_measuring_pending, aclk, aresetn, status.measuring,
        status.pending_mask != 8'd0)

    // A finished measurement either ends the scan or leaves work pending.
    `CCS_ASSERT_SAME(a_done_vs_busy, aclk, aresetn,
        m_tvalid && m_tuser[0] == ccs_pkg::KIND_MEASURE, m_tlast != m_tdata[19])

    // A result that completes the scan leaves no pending channel behind.
    `CCS_ASSERT_NEXT(a_done_clears, aclk, aresetn,
        res_valid && item_valid && advance && res.scan_done,
        status.pending_mask == 8'd0)

endmodule

// File: sim/tb_capacitive_channel_scanner.sv
// ---------------------------------------------------------------------------
// Testbench for the capacitive channel scanner
// A table of directed transactions, then random scan sequences with register
// changes between phases. Each result is checked against a cycle-free scan
// predictor or a table result while both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_capacitive_channel_scanner;

    localparam int RESULT_LATENCY = 2;
    localparam int STALL_LIMIT    = 1000;
    localparam int RANDOM_ITEMS   = 760;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        ccs_pkg::op_t                   op;
        logic [2:0]                     rch;
        logic [ccs_pkg::CFG_ADDR_W-1:0] addr;
        logic [7:0]                     data;
        int                             reps;
        bit                             known;
        ccs_pkg::result_t               res;
    } plan_row_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [ccs_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;  // [2:0] read_channel, rest zero
    logic [1:0]                     s_tuser   = '0;  // [1:0] operation
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [23:0]                    m_tdata;  // [2:0] channel, [18:3] value, [19] busy_res
    logic [0:0]                     m_tuser;  // [0] result_kind
    logic                           m_tlast;  // scan_done

    // Scan state as the predictor sees it.
    logic [7:0]  enabled_mask    = 8'h00;
    logic [7:0]  crossing_target = ccs_pkg::CROSSINGS_RESET;
    logic [7:0]  pending         = 8'h00;
    logic [2:0]  active_ch       = 3'd0;
    logic [7:0]  crossings_seen  = 8'h00;
    logic [15:0] ticks_seen      = 16'h0000;
    logic        scanning        = 1'b0;
    logic [15:0] stored_ticks [8];

    ccs_pkg::result_t awaited_reports [$];
    plan_row_t        directed_plan [$];
    int               errors       = 0;
    int               burst_left   = 0;
    int               quiet_cycles = 0;
    int               rx_cycle     = 0;

    capacitive_channel_scanner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [2:0] top_channel(input logic [7:0] mask);
        for (int b = 7; b >= 0; b--) begin
            if (mask[b]) begin
                return 3'(b);
            end
        end
        return 3'd0;
    endfunction

    // Advances the scan state by one accepted transaction and reports the
    // result that it causes, if any.
    function automatic bit track_scan(input ccs_pkg::op_t op, input logic [2:0] rch,
                                      output ccs_pkg::result_t report);
        report = '0;
        case (op)
            ccs_pkg::OP_START: begin
                if (enabled_mask != 8'h00) begin
                    if (pending == 8'h00) begin
                        pending   = enabled_mask;
                        active_ch = top_channel(pending);
                    end
                    crossings_seen = 8'h00;
                    ticks_seen     = 16'h0000;
                    scanning       = 1'b1;
                end
                return 1'b0;
            end
            ccs_pkg::OP_TICK: begin
                if (scanning) begin
                    ticks_seen = ticks_seen + 16'd1;
                end
                return 1'b0;
            end
            ccs_pkg::OP_CROSS: begin
                if (!scanning) begin
                    return 1'b0;
                end
                crossings_seen = crossings_seen + 8'd1;
                if (crossings_seen != crossing_target) begin
                    return 1'b0;
                end
                stored_ticks[active_ch] = ticks_seen;
                pending[active_ch]      = 1'b0;
                report = ccs_pkg::result_t'{ccs_pkg::KIND_MEASURE, active_ch, ticks_seen,
                                            pending == 8'h00, pending != 8'h00};
                crossings_seen = 8'h00;
                ticks_seen     = 16'h0000;
                scanning       = 1'b0;
                // With the mask cleared the next channel is chosen but waits
                // for a start.
                if (pending != 8'h00) begin
                    active_ch = top_channel(pending);
                    scanning  = (enabled_mask != 8'h00);
                end
                return 1'b1;
            end
            default: begin
                report = ccs_pkg::result_t'{ccs_pkg::KIND_READ, rch, stored_ticks[rch],
                                            1'b0, pending != 8'h00};
                return 1'b1;
            end
        endcase
    endfunction

    function automatic plan_row_t item_row(input ccs_pkg::op_t op, input logic [2:0] rch,
                                           input int reps);
        plan_row_t row;
        row.kind  = ROW_ITEM;
        row.op    = op;
        row.rch   = rch;
        row.addr  = '0;
        row.data  = 8'd0;
        row.reps  = reps;
        row.known = 1'b0;
        row.res   = '0;
        return row;
    endfunction

    function automatic plan_row_t known_row(input ccs_pkg::op_t op, input logic [2:0] rch,
                                            input ccs_pkg::result_t res);
        plan_row_t row;
        row       = item_row(op, rch, 1);
        row.known = 1'b1;
        row.res   = res;
        return row;
    endfunction

    function automatic plan_row_t write_row(input logic [ccs_pkg::CFG_ADDR_W-1:0] addr,
                                            input logic [7:0] data);
        plan_row_t row;
        row       = item_row(ccs_pkg::OP_START, 3'd0, 0);
        row.kind  = ROW_WRITE;
        row.addr  = addr;
        row.data  = data;
        return row;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input ccs_pkg::op_t op, input logic [2:0] rch,
                             input bit known, input ccs_pkg::result_t res);
        ccs_pkg::result_t predicted;
        int               gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, rch};
        do @(posedge aclk); while (!s_tready);
        if (track_scan(op, rch, predicted)) begin
            awaited_reports.push_back(known ? res : predicted);
        end
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(negedge aclk);
        repeat (RESULT_LATENCY + 2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ccs_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == ccs_pkg::CFG_ENABLED) begin
            enabled_mask = data;
        end else begin
            crossing_target = data;
        end
        @(negedge aclk);
    endtask

    // The receiver cycles through always ready, random stalls and a sparse
    // periodic pattern.
    always @(negedge aclk) begin
        rx_cycle = rx_cycle + 1;
        case ((rx_cycle / 128) % 3)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (rx_cycle % 8 == 0);
        endcase
    end

    always @(posedge aclk) begin
        ccs_pkg::result_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_capacitive_channel_scanner: done, errors");
                $finish;
            end else if (m_tvalid && m_tready) begin
                if (awaited_reports.size() == 0) begin
                    $error("unexpected result transaction: kind %0d channel %0d value %0d",
                           m_tuser[0], m_tdata[2:0], m_tdata[18:3]);
                    errors++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (m_tuser[0] !== want.result_kind) begin
                        $error("result_kind: expected %0d, actual %0d",
                               want.result_kind, m_tuser[0]);
                        errors++;
                    end
                    if (m_tdata[2:0] !== want.channel) begin
                        $error("channel: expected %0d, actual %0d", want.channel, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[18:3] !== want.value) begin
                        $error("value: expected %0d, actual %0d", want.value, m_tdata[18:3]);
                        errors++;
                    end
                    if (m_tlast !== want.scan_done) begin
                        $error("scan_done: expected %0d, actual %0d", want.scan_done, m_tlast);
                        errors++;
                    end
                    if (m_tdata[19] !== want.busy_res) begin
                        $error("busy_res: expected %0d, actual %0d", want.busy_res, m_tdata[19]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        plan_row_t    row;
        ccs_pkg::op_t op;
        logic [2:0]   rch;
        int           phase;
        int           phase_len;
        int           cross_pct;
        int           pick;
        int           random_items;

        foreach (stored_ticks[i]) stored_ticks[i] = 16'h0000;

        // After reset every store reads zero and nothing is pending.
        directed_plan.push_back(known_row(ccs_pkg::OP_READ, 3'd0,
            ccs_pkg::result_t'{ccs_pkg::KIND_READ, 3'd0, 16'd0, 1'b0, 1'b0}));
        directed_plan.push_back(known_row(ccs_pkg::OP_READ, 3'd7,
            ccs_pkg::result_t'{ccs_pkg::KIND_READ, 3'd7, 16'd0, 1'b0, 1'b0}));
        // A start with no channel enabled, then ticks and crossings while idle.
        directed_plan.push_back(item_row(ccs_pkg::OP_START, 3'd5, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_TICK, 3'd2, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_CROSS, 3'd1, 1));
        // Two channels at the extremes, one crossing each.
        directed_plan.push_back(write_row(ccs_pkg::CFG_ENABLED, 8'h81));
        directed_plan.push_back(write_row(ccs_pkg::CFG_CROSSINGS, 8'd1));
        directed_plan.push_back(item_row(ccs_pkg::OP_START, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_TICK, 3'd0, 2));
        directed_plan.push_back(item_row(ccs_pkg::OP_CROSS, 3'd0, 2));
        directed_plan.push_back(item_row(ccs_pkg::OP_READ, 3'd7, 1));
        // A start in the middle of a measurement clears both counters.
        directed_plan.push_back(write_row(ccs_pkg::CFG_CROSSINGS, 8'd3));
        directed_plan.push_back(item_row(ccs_pkg::OP_START, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_TICK, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_CROSS, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_START, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_TICK, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_CROSS, 3'd0, 6));
        // Clearing the mask mid-scan parks the next channel until a start.
        directed_plan.push_back(write_row(ccs_pkg::CFG_ENABLED, 8'hC0));
        directed_plan.push_back(write_row(ccs_pkg::CFG_CROSSINGS, 8'd1));
        directed_plan.push_back(item_row(ccs_pkg::OP_START, 3'd0, 1));
        directed_plan.push_back(write_row(ccs_pkg::CFG_ENABLED, 8'h00));
        directed_plan.push_back(item_row(ccs_pkg::OP_CROSS, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_TICK, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_CROSS, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_READ, 3'd6, 1));
        directed_plan.push_back(write_row(ccs_pkg::CFG_ENABLED, 8'h01));
        directed_plan.push_back(item_row(ccs_pkg::OP_START, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_TICK, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_CROSS, 3'd0, 1));
        // A capture right after the start reports zero ticks and ends the scan.
        directed_plan.push_back(item_row(ccs_pkg::OP_START, 3'd0, 1));
        directed_plan.push_back(known_row(ccs_pkg::OP_CROSS, 3'd0,
            ccs_pkg::result_t'{ccs_pkg::KIND_MEASURE, 3'd0, 16'd0, 1'b1, 1'b0}));
        // A crossing setting of zero waits for 256 crossings.
        directed_plan.push_back(write_row(ccs_pkg::CFG_CROSSINGS, 8'd0));
        directed_plan.push_back(item_row(ccs_pkg::OP_START, 3'd0, 1));
        directed_plan.push_back(item_row(ccs_pkg::OP_TICK, 3'd0, 3));
        directed_plan.push_back(item_row(ccs_pkg::OP_CROSS, 3'd0, 256));
        directed_plan.push_back(item_row(ccs_pkg::OP_READ, 3'd0, 1));

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.kind == ROW_WRITE) begin
                wait_quiet();
                write_reg(row.addr, row.data);
            end else begin
                repeat (row.reps) send_item(row.op, row.rch, row.known, row.res);
            end
        end

        // Random phases: registers change only once the block has drained.
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_quiet();
            if (phase == 2 || phase == 6) begin
                write_reg(ccs_pkg::CFG_CROSSINGS, (phase == 2) ? 8'd255 : 8'd0);
                write_reg(ccs_pkg::CFG_ENABLED, 8'h01 << $urandom_range(0, 7));
                phase_len = 320;
                cross_pct = 85;
            end else begin
                if (phase == 0 || $urandom_range(0, 9) < 7) begin
                    case ($urandom_range(0, 4))
                        0:       write_reg(ccs_pkg::CFG_ENABLED, 8'h00);
                        1:       write_reg(ccs_pkg::CFG_ENABLED, 8'hFF);
                        2:       write_reg(ccs_pkg::CFG_ENABLED,
                                           8'h01 << $urandom_range(0, 7));
                        default: write_reg(ccs_pkg::CFG_ENABLED,
                                           8'($urandom_range(1, 255)));
                    endcase
                end
                if (phase == 0 || $urandom_range(0, 9) < 6) begin
                    write_reg(ccs_pkg::CFG_CROSSINGS,
                              ($urandom_range(0, 2) == 0) ? 8'd1
                                                          : 8'($urandom_range(2, 5)));
                end
                phase_len = $urandom_range(20, 90);
                cross_pct = 40;
            end
            for (int k = 0; k < phase_len && random_items < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                rch  = 3'($urandom_range(0, 7));
                if (!scanning) begin
                    op = (pick < 55) ? ccs_pkg::OP_START : (pick < 70) ? ccs_pkg::OP_READ
                       : (pick < 85) ? ccs_pkg::OP_TICK : ccs_pkg::OP_CROSS;
                end else begin
                    op = (pick < 2) ? ccs_pkg::OP_START : (pick < 7) ? ccs_pkg::OP_READ
                       : (pick < 7 + (93 * cross_pct) / 100) ? ccs_pkg::OP_CROSS
                       : ccs_pkg::OP_TICK;
                end
                random_items++;
                send_item(op, rch, 1'b0, ccs_pkg::result_t'('0));
            end
            phase++;
        end

        wait_quiet();
        if (errors == 0) begin
            $display("tb_capacitive_channel_scanner: done, clean");
        end else begin
            $display("tb_capacitive_channel_scanner: done, errors");
        end
        $finish;
    end

endmodule
